/* rtl/rdzp_pkg.sv */
// Shared constants, types and field layout of the row delta zero run packer.
package rdzp_pkg;

  localparam int MAX_WIDTH   = 8192;
  localparam int SAMPLE_BITS = 14;
  localparam int RUN_BITS    = 24;

  localparam int DELTA_W  = SAMPLE_BITS + 1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int W_W      = $clog2(MAX_WIDTH + 1);
  localparam int FW_REG_W = 14;
  localparam int HGT_W    = 14;
  localparam int ROW_W    = 13;
  localparam int W_MIN    = 16;
  localparam int H_MIN    = 2;
  localparam int H_MAX    = 8192;

  localparam int Q_W          = 7;
  localparam int Q_MIN        = 1;
  localparam int Q_MAX        = 100;
  localparam int Q_DIV3_MUL   = 171;
  localparam int Q_DIV3_SHIFT = 9;
  localparam int THR_BASE     = 48;
  localparam int EXTRA_W      = 8;
  localparam int THR_W        = 9;
  localparam int SHIFT_W      = 3;
  localparam int SHIFT_MAX    = 4;
  localparam int CMP_W        = 16;
  localparam int SHORT_MAX    = 127;

  localparam int BYTE_W       = 31;
  localparam int HEADER_BYTES = 16;
  localparam int CAP_MIN      = 64;
  localparam int MARK_BYTES   = 2;
  localparam int SHORT_NEED   = 3;
  localparam int SHORT_BYTES  = 1;
  localparam int LONG_BYTES   = 4;
  localparam int CHUNK_BYTES  = 4;
  localparam int SMALL_CHUNK_BYTES = 2;
  localparam int SMALL_CHUNK_MAX   = 255;

  localparam int CHUNK_W = 16;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX = 16'hFFFF;
  localparam int KCNT_W  = RUN_BITS - 15;
  localparam logic [RUN_BITS-1:0] RUN_FLUSH =
    RUN_BITS'((((64'd1 << RUN_BITS) - 64'd1) / 64'(CHUNK_MAX)) * 64'(CHUNK_MAX));

  localparam int ROWI_W = 8;
  localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int OUT_ROW_LSB   = 0;
  localparam int OUT_RUN_LSB   = OUT_ROW_LSB + ROWI_W;
  localparam int OUT_DELTA_LSB = OUT_RUN_LSB + RUN_BITS;
  localparam int OUT_BYTES_LSB = OUT_DELTA_LSB + DELTA_W;
  localparam int OUT_OVF_BIT   = OUT_BYTES_LSB + BYTE_W;
  localparam int OUT_BITS      = OUT_OVF_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int KIND_W        = 2;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUALITY  = 3'd0,
    CFG_EXTRA    = 3'd1,
    CFG_SHIFT    = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_CAPACITY = 3'd5
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    TK_MARK  = 2'd0,
    TK_RUN   = 2'd1,
    TK_SHORT = 2'd2,
    TK_LONG  = 2'd3
  } tok_kind_e;

  typedef enum logic [1:0] {
    PH_MARK  = 2'd0,
    PH_BODY  = 2'd1,
    PH_DELTA = 2'd2
  } phase_e;

  typedef struct packed {
    logic [THR_W-1:0]   thr;
    logic [SHIFT_W-1:0] shift;
    logic [W_W-1:0]     width;
    logic [HGT_W-1:0]   height;
    logic [BYTE_W-1:0]  cap;
  } cfg_t;

  typedef struct packed {
    logic               mk;
    logic [ROWI_W-1:0]  row_idx;
    logic               zero;
    logic               shrt;
    logic               last;
    logic [DELTA_W-1:0] delta;
  } fentry_t;

  typedef struct packed {
    tok_kind_e           kind;
    logic [ROWI_W-1:0]   row;
    logic [RUN_BITS-1:0] run;
    logic [DELTA_W-1:0]  delta;
    logic [BYTE_W-1:0]   bytes;
    logic                ovf;
    logic                last;
  } tok_t;

endpackage

/* rtl/row_delta_zero_run_packer_top.sv */
// Top level of the row delta zero run packer.
// Takes one 14-bit sample per transaction in row order (tlast marks end of data) and
// emits row marker, zero run and delta tokens, one per transaction, with the running
// byte position, an overflow flag and tlast on the final token of a frame. The front
// end classifies a sample in the cycle it is accepted and pushes it into a four-entry
// queue, so input is taken every cycle while the queue has room. The back end works
// one step per cycle, waiting while a token is due and the output register is full;
// each extra token a sample causes (row marker, run flush ahead of a delta) takes one
// more step. The output register moves at most one token per cycle. Configuration
// writes apply at once and are meant to be made only while the block is idle.
module row_delta_zero_run_packer_top import rdzp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // sample, zero pad
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // row_index, run_length, delta_value,
                                                   // bytes_so_far, overflow, zero pad
  output logic [KIND_W-1:0]      m_axis_tuser_o,   // token_kind
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t    cfg;
  logic    push, fifo_ready, head_valid, pop;
  fentry_t entry, head;
  tok_t    tok;

  assign s_axis_tready_o = fifo_ready;

  rdzp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rdzp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s_axis_tvalid_i),
    .ready_i  (fifo_ready),
    .sample_i (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .eod_i    (s_axis_tlast_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  rdzp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .ready_o      (fifo_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rdzp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .tok_valid_o  (m_axis_tvalid_o),
    .tok_ready_i  (m_axis_tready_i),
    .tok_o        (tok)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({tok.ovf, tok.bytes, tok.delta, tok.run, tok.row});
  assign m_axis_tuser_o = tok.kind;
  assign m_axis_tlast_o = tok.last;

endmodule

/* rtl/rdzp_cfg.sv */
// Configuration registers with clamping and delta threshold derivation.
module rdzp_cfg import rdzp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [Q_W-1:0]      quality_q;
  logic [EXTRA_W-1:0]  extra_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [FW_REG_W-1:0] width_q;
  logic [HGT_W-1:0]    height_q;
  logic [BYTE_W-1:0]   cap_q;

  logic [Q_W-1:0]  q_eff;
  logic [14:0]     q_mul;
  logic [5:0]      q_div3;
  logic [5:0]      thr_base;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_q <= Q_W'(85);
      extra_q   <= '0;
      shift_q   <= '0;
      width_q   <= FW_REG_W'(1920);
      height_q  <= HGT_W'(1080);
      cap_q     <= BYTE_W'(16777216);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUALITY:  quality_q <= cfg_data_i[Q_W-1:0];
        CFG_EXTRA:    extra_q   <= cfg_data_i[EXTRA_W-1:0];
        CFG_SHIFT:    shift_q   <= cfg_data_i[SHIFT_W-1:0];
        CFG_WIDTH:    width_q   <= cfg_data_i[FW_REG_W-1:0];
        CFG_HEIGHT:   height_q  <= cfg_data_i[HGT_W-1:0];
        CFG_CAPACITY: cap_q     <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (quality_q < Q_W'(Q_MIN)) begin
      q_eff = Q_W'(Q_MIN);
    end else if (quality_q > Q_W'(Q_MAX)) begin
      q_eff = Q_W'(Q_MAX);
    end else begin
      q_eff = quality_q;
    end
    // q/3 by reciprocal, exact for q below 512; base stays >= 15 so no floor at 1
    q_mul    = 15'(q_eff) * 15'(Q_DIV3_MUL);
    q_div3   = 6'(q_mul >> Q_DIV3_SHIFT);
    thr_base = 6'(THR_BASE) - q_div3;
    cfg_o.thr = THR_W'(thr_base) + THR_W'(extra_q);

    cfg_o.shift = (shift_q > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift_q;

    if (32'(width_q) > 32'(MAX_WIDTH)) begin
      cfg_o.width = W_W'(MAX_WIDTH);
    end else if (width_q < FW_REG_W'(W_MIN)) begin
      cfg_o.width = W_W'(W_MIN);
    end else begin
      cfg_o.width = W_W'(width_q);
    end

    if (height_q < HGT_W'(H_MIN)) begin
      cfg_o.height = HGT_W'(H_MIN);
    end else if (height_q > HGT_W'(H_MAX)) begin
      cfg_o.height = HGT_W'(H_MAX);
    end else begin
      cfg_o.height = height_q;
    end

    cfg_o.cap = (cap_q < BYTE_W'(CAP_MIN)) ? BYTE_W'(CAP_MIN) : cap_q;
  end

endmodule

/* rtl/rdzp_front.sv */
// Front end: quantizes, differences and classifies samples, tracks row position.
module rdzp_front import rdzp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   valid_i,
  input  logic                   ready_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   eod_i,
  output logic                   push_o,
  output fentry_t                entry_o
);

  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [ROW_W-1:0]       row_q, row_d;

  logic [SAMPLE_BITS-1:0] qmask, cur, prev;
  logic [DELTA_W-1:0]     d, dneg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [W_W-1:0]         col_p1;
  logic [HGT_W-1:0]       row_p1;
  logic                   first, row_end, last;

  assign push_o = valid_i && ready_i;

  always_comb begin
    qmask   = ~((SAMPLE_BITS'(1) << cfg_i.shift) - SAMPLE_BITS'(1));
    cur     = sample_i & qmask;
    first   = (col_q == '0);
    prev    = first ? '0 : prev_q;
    d       = {1'b0, cur} - {1'b0, prev};
    dneg    = '0 - d;
    mag     = d[DELTA_W-1] ? dneg[SAMPLE_BITS-1:0] : d[SAMPLE_BITS-1:0];
    col_p1  = W_W'(col_q) + W_W'(1);
    row_p1  = HGT_W'(row_q) + HGT_W'(1);
    row_end = (col_p1 >= cfg_i.width);
    last    = eod_i || (row_end && (row_p1 >= cfg_i.height));

    entry_o.mk      = first;
    entry_o.row_idx = row_q[ROWI_W-1:0];
    entry_o.zero    = (CMP_W'(mag) <= CMP_W'(cfg_i.thr));
    entry_o.shrt    = (CMP_W'(mag) <= CMP_W'(SHORT_MAX));
    entry_o.last    = last;
    entry_o.delta   = d;

    prev_d = prev_q;
    col_d  = col_q;
    row_d  = row_q;
    if (push_o) begin
      prev_d = cur;
      if (last) begin
        prev_d = '0;
        col_d  = '0;
        row_d  = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      prev_q <= prev_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

/* rtl/rdzp_fifo.sv */
// Short queue of classified samples between front and back.
module rdzp_fifo import rdzp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  fentry_t entry_i,
  output logic    ready_o,
  input  logic    pop_i,
  output logic    head_valid_o,
  output fentry_t head_o
);

  fentry_t             mem_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_q, rd_q;
  logic [FQ_CNT_W-1:0] cnt_q;

  assign ready_o      = (cnt_q != FQ_CNT_W'(FQ_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FQ_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FQ_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FQ_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FQ_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/rdzp_back.sv */
// Back end: run counting, byte accounting, capacity checks and token emission.
module rdzp_back import rdzp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    head_valid_i,
  input  fentry_t head_i,
  output logic    pop_o,
  output logic    tok_valid_o,
  input  logic    tok_ready_i,
  output tok_t    tok_o
);

  phase_e              phase_q, phase_d;
  logic [BYTE_W-1:0]   pos_q, pos_d;
  logic [RUN_BITS-1:0] pz_q, pz_d;
  logic [KCNT_W-1:0]   k_q, k_d;
  logic [CHUNK_W-1:0]  m_q, m_d;
  logic                failed_q, failed_d;
  logic                valid_q;
  tok_t                tok_q, tok_d;

  logic                out_free, emit, done, body_go, delta_go, flush_z;
  logic [RUN_BITS-1:0] pz1, rpz;
  logic [KCNT_W-1:0]   k1, rk, nch;
  logic [CHUNK_W-1:0]  m1, rm;
  logic [2:0]          tail;
  logic [31:0]         pos32, cap32, mk_pos, run_pos, dl_pos;
  logic                mk_ovf, run_ovf, dl_ovf;

  assign out_free    = !valid_q || tok_ready_i;
  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign pop_o       = done;

  always_comb begin
    pz1 = pz_q + RUN_BITS'(1);
    if (m_q == CHUNK_MAX - CHUNK_W'(1)) begin
      m1 = '0;
      k1 = k_q + KCNT_W'(1);
    end else begin
      m1 = m_q + CHUNK_W'(1);
      k1 = k_q;
    end
    flush_z = (pz1 >= RUN_FLUSH) || head_i.last;

    rpz = head_i.zero ? pz1 : pz_q;
    rk  = head_i.zero ? k1 : k_q;
    rm  = head_i.zero ? m1 : m_q;
    nch = rk + KCNT_W'(rm != '0);
    if (rm == '0) begin
      tail = '0;
    end else if (rm <= CHUNK_W'(SMALL_CHUNK_MAX)) begin
      tail = 3'(SMALL_CHUNK_BYTES);
    end else begin
      tail = 3'(CHUNK_BYTES);
    end

    pos32   = {1'b0, pos_q};
    cap32   = {1'b0, cfg_i.cap};
    mk_pos  = pos32 + 32'(MARK_BYTES);
    mk_ovf  = mk_pos > cap32;
    run_ovf = (pos32 + (32'(nch) << 2)) > cap32;
    run_pos = pos32 + (32'(rk) << 2) + 32'(tail);
    dl_ovf  = (pos32 + (head_i.shrt ? 32'(SHORT_NEED) : 32'(LONG_BYTES))) > cap32;
    dl_pos  = pos32 + (head_i.shrt ? 32'(SHORT_BYTES) : 32'(LONG_BYTES));
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    pz_d     = pz_q;
    k_d      = k_q;
    m_d      = m_q;
    failed_d = failed_q;
    tok_d    = '0;
    emit     = 1'b0;
    done     = 1'b0;
    body_go  = 1'b0;
    delta_go = 1'b0;

    if (head_valid_i) begin
      case (phase_q)
        PH_MARK: begin
          if (head_i.mk && !failed_q) begin
            if (out_free) begin
              emit       = 1'b1;
              tok_d.kind = TK_MARK;
              tok_d.row  = head_i.row_idx;
              tok_d.ovf  = mk_ovf;
              tok_d.last = mk_ovf;
              if (mk_ovf) begin
                tok_d.bytes = pos_q;
                failed_d    = 1'b1;
              end else begin
                tok_d.bytes = mk_pos[BYTE_W-1:0];
                pos_d       = mk_pos[BYTE_W-1:0];
              end
              phase_d = PH_BODY;
            end
          end else begin
            body_go = 1'b1;
          end
        end
        PH_BODY:  body_go  = 1'b1;
        PH_DELTA: delta_go = 1'b1;
        default:  phase_d  = PH_MARK;
      endcase

      if (body_go) begin
        if (failed_q) begin
          done = 1'b1;
        end else if (head_i.zero && !flush_z) begin
          pz_d = pz1;
          k_d  = k1;
          m_d  = m1;
          done = 1'b1;
        end else if (head_i.zero || (pz_q != '0)) begin
          if (out_free) begin
            emit       = 1'b1;
            tok_d.kind = TK_RUN;
            tok_d.run  = rpz;
            tok_d.ovf  = run_ovf;
            tok_d.last = run_ovf || (head_i.zero && head_i.last);
            pz_d       = '0;
            k_d        = '0;
            m_d        = '0;
            if (run_ovf) begin
              tok_d.bytes = pos_q;
              failed_d    = 1'b1;
            end else begin
              tok_d.bytes = run_pos[BYTE_W-1:0];
              pos_d       = run_pos[BYTE_W-1:0];
            end
            if (run_ovf || head_i.zero) begin
              done = 1'b1;
            end else begin
              phase_d = PH_DELTA;
            end
          end
        end else begin
          delta_go = 1'b1;
        end
      end

      if (delta_go && out_free) begin
        emit        = 1'b1;
        tok_d.kind  = head_i.shrt ? TK_SHORT : TK_LONG;
        tok_d.delta = head_i.delta;
        tok_d.ovf   = dl_ovf;
        tok_d.last  = dl_ovf || head_i.last;
        if (dl_ovf) begin
          tok_d.bytes = pos_q;
          failed_d    = 1'b1;
        end else begin
          tok_d.bytes = dl_pos[BYTE_W-1:0];
          pos_d       = dl_pos[BYTE_W-1:0];
        end
        done = 1'b1;
      end

      if (done) begin
        phase_d = PH_MARK;
        if (head_i.last) begin
          pos_d    = BYTE_W'(HEADER_BYTES);
          pz_d     = '0;
          k_d      = '0;
          m_d      = '0;
          failed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MARK;
      pos_q    <= BYTE_W'(HEADER_BYTES);
      pz_q     <= '0;
      k_q      <= '0;
      m_q      <= '0;
      failed_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      pz_q     <= pz_d;
      k_q      <= k_d;
      m_q      <= m_d;
      failed_q <= failed_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (tok_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tok_q <= tok_d;
    end
  end

endmodule

/* rtl/rdzp_checker.sv */
// Port-level assertions for the row delta zero run packer, bound to the top level.
module rdzp_checker import rdzp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [KIND_W-1:0]      m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  logic [RUN_BITS-1:0] run_f;
  logic [DELTA_W-1:0]  delta_f;
  logic [BYTE_W-1:0]   bytes_f;
  logic                ovf_f;

  assign run_f   = m_axis_tdata_o[OUT_RUN_LSB +: RUN_BITS];
  assign delta_f = m_axis_tdata_o[OUT_DELTA_LSB +: DELTA_W];
  assign bytes_f = m_axis_tdata_o[OUT_BYTES_LSB +: BYTE_W];
  assign ovf_f   = m_axis_tdata_o[OUT_OVF_BIT];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ovf_f |-> m_axis_tlast_o)
    else $error("overflow token not marked as final");

  a_mark_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == TK_MARK) |-> (run_f == '0) && (delta_f == '0))
    else $error("row marker carries run or delta");

  a_pos_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> bytes_f >= BYTE_W'(HEADER_BYTES))
    else $error("byte position below header size");

endmodule

bind row_delta_zero_run_packer_top rdzp_checker u_rdzp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
